@@ src/lbm_pkg.sv @@
// ============================================================================
// lbm_pkg
// Shared widths, status codes and sideband structures of the Lorentz boost
// pipeline.
// ============================================================================
package lbm_pkg;

    localparam int BF   = 22;
    localparam int GF   = 30;
    localparam int BW   = 24;
    localparam int PW   = 32;
    localparam int EW   = 31;
    localparam int MCW  = 32;

    localparam int B2W  = 2 * BW;
    localparam int XW   = (B2W > 2 * BF + 1) ? B2W : 2 * BF + 1;
    localparam int DOTW = BW + PW + 2;
    localparam int DW1  = 2 * BF + 1;
    localparam int QW   = 2 * (BF + GF) + 1;
    localparam int SQW  = QW + 1;
    localparam int GW   = SQW / 2;
    localparam int GEW  = GW + EW;
    localparam int CDW  = GW + DOTW;
    localparam int UW   = CDW + 2;
    localparam int USW  = UW - BF;
    localparam int PRW  = USW + BW + 1;
    localparam int TW   = PRW - GF - BF;

    localparam logic [XW-1:0] ONE2 = XW'(1) << (2 * BF);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAST = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [2:0][BW-1:0] b;
        logic [2:0][PW-1:0] p;
        logic [EW-1:0]      e;
        logic [DOTW-1:0]    dmag;
        logic               dneg;
        logic               zero;
        logic               over;
    } t_kin;

    typedef struct packed {
        t_kin          k;
        logic [GW-1:0] g;
    } t_kg;

    typedef struct packed {
        t_kin           k;
        logic [GEW-1:0] ge;
    } t_kge;

    typedef struct packed {
        logic [2:0][PW-1:0] p;
        logic [2:0]         neg;
        logic               zero;
        logic               over;
    } t_sv;

    typedef struct packed {
        logic [2:0][PW-1:0] o;
        logic [1:0]         st;
    } t_res;

endpackage

@@ src/lbm_div_cell.sv @@
// ============================================================================
// lbm_div_cell
// One restoring division step: shifts in a dividend bit, yields a quotient bit.
// ============================================================================
module lbm_div_cell
    import lbm_pkg::*;
#(
    parameter int DW = 45,
    parameter int QB = 105,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [QB-1:0] i_nq,
    input  logic [DW-1:0] i_d,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [QB-1:0] o_nq,
    output logic [DW-1:0] o_d,
    output logic [SW-1:0] o_side
);

    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] n_rem;
    logic          r_v;
    logic [DW-1:0] r_rem;
    logic [QB-1:0] r_nq;
    logic [DW-1:0] r_d;
    logic [SW-1:0] r_side;

    always_comb begin
        t     = {i_rem, i_nq[QB-1]};
        ge    = (t >= {1'b0, i_d});
        n_rem = ge ? DW'(t - {1'b0, i_d}) : t[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_nq   <= {i_nq[QB-2:0], ge};
            r_d    <= i_d;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;
    assign o_d     = r_d;
    assign o_side  = r_side;

endmodule

@@ src/lbm_sqrt_cell.sv @@
// ============================================================================
// lbm_sqrt_cell
// One digit-by-digit square root step: consumes two radicand bits per cell.
// ============================================================================
module lbm_sqrt_cell
    import lbm_pkg::*;
#(
    parameter int NW = 106,
    parameter int GW = 53,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [GW:0]   i_rem,
    input  logic [GW-1:0] i_res,
    input  logic [NW-1:0] i_x,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [GW:0]   o_rem,
    output logic [GW-1:0] o_res,
    output logic [NW-1:0] o_x,
    output logic [SW-1:0] o_side
);

    logic [GW+2:0] t;
    logic [GW+2:0] trial;
    logic          ge;
    logic [GW:0]   n_rem;
    logic          r_v;
    logic [GW:0]   r_rem;
    logic [GW-1:0] r_res;
    logic [NW-1:0] r_x;
    logic [SW-1:0] r_side;

    always_comb begin
        t     = {i_rem, i_x[NW-1:NW-2]};
        trial = {1'b0, i_res, 2'b01};
        ge    = (t >= trial);
        n_rem = ge ? (GW+1)'(t - trial) : t[GW:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_res  <= {i_res[GW-2:0], ge};
            r_x    <= {i_x[NW-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem   = r_rem;
    assign o_res   = r_res;
    assign o_x     = r_x;
    assign o_side  = r_side;

endmodule

@@ src/lbm_mul.sv @@
// ============================================================================
// lbm_mul
// Two-stage unsigned multiplier, split into 32x32 partial products, with a
// shared multiplicand across lanes.
// ============================================================================
module lbm_mul
    import lbm_pkg::*;
#(
    parameter int WA    = 53,
    parameter int WB    = 53,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [WA-1:0]                  i_a,
    input  logic [LANES-1:0][WB-1:0]       i_b,
    input  logic [SW-1:0]                  i_side,
    output logic                           o_valid,
    output logic [LANES-1:0][WA+WB-1:0]    o_p,
    output logic [SW-1:0]                  o_side
);

    localparam int NA   = (WA + MCW - 1) / MCW;
    localparam int NB   = (WB + MCW - 1) / MCW;
    localparam int SUMW = (NA + NB) * MCW;

    logic [NA*MCW-1:0]                       a_pad;
    logic [LANES-1:0][NB*MCW-1:0]            b_pad;
    logic [LANES-1:0][NA-1:0][NB-1:0][2*MCW-1:0] r_pp;
    logic [LANES-1:0][SUMW-1:0]              sum;
    logic [LANES-1:0][WA+WB-1:0]             r_p;
    logic                                    r_v1;
    logic                                    r_v2;
    logic [SW-1:0]                           r_s1;
    logic [SW-1:0]                           r_s2;

    always_comb begin
        a_pad = (NA*MCW)'(i_a);
        for (int l = 0; l < LANES; l++) begin
            b_pad[l] = (NB*MCW)'(i_b[l]);
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sum[l] = '0;
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    sum[l] = sum[l] + (SUMW'(r_pp[l][i][j]) << ((i + j) * MCW));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int i = 0; i < NA; i++) begin
                    for (int j = 0; j < NB; j++) begin
                        r_pp[l][i][j] <= (2*MCW)'(a_pad[i*MCW +: MCW])
                                       * (2*MCW)'(b_pad[l][j*MCW +: MCW]);
                    end
                end
                r_p[l] <= sum[l][WA+WB-1:0];
            end
            r_s1 <= i_side;
            r_s2 <= r_s1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_side  = r_s2;

endmodule

@@ src/lorentz_boost_momentum_top.sv @@
// Throughput: one transaction per cycle; the pipeline advances whenever the
// two-entry output buffer (output register plus skid) has room.
// Reset: synchronous, active low; clears all valid flags, no clearing pass.
// ============================================================================
// lorentz_boost_momentum_top
// Fixed-point Lorentz boost of a three-momentum: gamma by a chain of division
// and square root cells, then the boost terms and output saturation.
// ============================================================================
module lorentz_boost_momentum_top
    import lbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [BW-1:0] i_beta_x,
    input  logic signed [BW-1:0] i_beta_y,
    input  logic signed [BW-1:0] i_beta_z,
    input  logic signed [PW-1:0] i_mom_x,
    input  logic signed [PW-1:0] i_mom_y,
    input  logic signed [PW-1:0] i_mom_z,
    input  logic        [EW-1:0] i_energy_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [PW-1:0] o_out_x,
    output logic signed [PW-1:0] o_out_y,
    output logic signed [PW-1:0] o_out_z,
    output logic        [1:0]    o_status
);

    localparam int KW   = $bits(t_kin);
    localparam int KGW  = $bits(t_kg);
    localparam int KGEW = $bits(t_kge);
    localparam int SVW  = $bits(t_sv);

    logic r_sv;
    logic en;
    assign en = !r_sv;

    // ---------------- front end: squares, dot product, divisor
    logic [2:0][BW-1:0]         in_b;
    logic [2:0][PW-1:0]         in_p;
    logic                       r_v1, r_v2, r_v3;
    logic [2:0][BW-1:0]         r_b1, r_b2;
    logic [2:0][PW-1:0]         r_p1, r_p2;
    logic [EW-1:0]              r_e1, r_e2;
    logic [2:0][B2W-1:0]        r_bb1;
    logic [2:0][BW+PW-1:0]      r_bp1;
    logic [B2W-1:0]             r_b2sum;
    logic signed [DOTW-1:0]     r_dot;
    logic [B2W-1:0]             b2s;
    logic signed [DOTW-1:0]     dots;
    t_kin                       r_k3;
    logic [DW1-1:0]             r_d3;

    assign in_b = {i_beta_z, i_beta_y, i_beta_x};
    assign in_p = {i_mom_z, i_mom_y, i_mom_x};

    always_comb begin
        b2s  = '0;
        dots = '0;
        for (int i = 0; i < 3; i++) begin
            b2s  = b2s + r_bb1[i];
            dots = dots + DOTW'($signed(r_bp1[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_bb1[i] <= B2W'($signed(in_b[i]) * $signed(in_b[i]));
                r_bp1[i] <= (BW+PW)'($signed(in_b[i]) * $signed(in_p[i]));
            end
            r_b1     <= in_b;
            r_p1     <= in_p;
            r_e1     <= i_energy_in;
            r_b2sum  <= b2s;
            r_dot    <= dots;
            r_b2     <= r_b1;
            r_p2     <= r_p1;
            r_e2     <= r_e1;
            r_k3.b    <= r_b2;
            r_k3.p    <= r_p2;
            r_k3.e    <= r_e2;
            r_k3.dneg <= r_dot[DOTW-1];
            r_k3.dmag <= r_dot[DOTW-1] ? DOTW'(-r_dot) : DOTW'(r_dot);
            r_k3.zero <= (r_b2sum == '0);
            r_k3.over <= (XW'(r_b2sum) >= ONE2);
            r_d3      <= DW1'(ONE2 - XW'(r_b2sum));
        end
    end

    // ---------------- gamma^2 = 1 / (1 - beta^2): division cells
    logic               d1_v    [0:QW];
    logic [DW1-1:0]     d1_rem  [0:QW];
    logic [QW-1:0]      d1_nq   [0:QW];
    logic [DW1-1:0]     d1_d    [0:QW];
    logic [KW-1:0]      d1_side [0:QW];

    assign d1_v[0]    = r_v3;
    assign d1_rem[0]  = '0;
    assign d1_nq[0]   = QW'(1) << (QW - 1);
    assign d1_d[0]    = r_d3;
    assign d1_side[0] = r_k3;

    for (genvar c = 0; c < QW; c++) begin : g_div1
        lbm_div_cell #(.DW(DW1), .QB(QW), .SW(KW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d1_v[c]),
            .i_rem   (d1_rem[c]),
            .i_nq    (d1_nq[c]),
            .i_d     (d1_d[c]),
            .i_side  (d1_side[c]),
            .o_valid (d1_v[c+1]),
            .o_rem   (d1_rem[c+1]),
            .o_nq    (d1_nq[c+1]),
            .o_d     (d1_d[c+1]),
            .o_side  (d1_side[c+1])
        );
    end

    // ---------------- gamma: square root cells
    logic               sq_v    [0:GW];
    logic [GW:0]        sq_rem  [0:GW];
    logic [GW-1:0]      sq_res  [0:GW];
    logic [SQW-1:0]     sq_x    [0:GW];
    logic [KW-1:0]      sq_side [0:GW];

    assign sq_v[0]    = d1_v[QW];
    assign sq_rem[0]  = '0;
    assign sq_res[0]  = '0;
    assign sq_x[0]    = {1'b0, d1_nq[QW]};
    assign sq_side[0] = d1_side[QW];

    for (genvar c = 0; c < GW; c++) begin : g_sqrt
        lbm_sqrt_cell #(.NW(SQW), .GW(GW), .SW(KW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[c]),
            .i_rem   (sq_rem[c]),
            .i_res   (sq_res[c]),
            .i_x     (sq_x[c]),
            .i_side  (sq_side[c]),
            .o_valid (sq_v[c+1]),
            .o_rem   (sq_rem[c+1]),
            .o_res   (sq_res[c+1]),
            .o_x     (sq_x[c+1]),
            .o_side  (sq_side[c+1])
        );
    end

    // ---------------- g*g and g*E
    t_kg                        mg_in_side;
    t_kg                        mg_side;
    logic [1:0][GW-1:0]         mg_b;
    logic [1:0][2*GW-1:0]       mg_p;
    logic                       mg_v;

    assign mg_in_side.k = t_kin'(sq_side[GW]);
    assign mg_in_side.g = sq_res[GW];
    assign mg_b[0]      = sq_res[GW];
    assign mg_b[1]      = GW'(mg_in_side.k.e);

    lbm_mul #(.WA(GW), .WB(GW), .LANES(2), .SW(KGW)) u_mul_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v[GW]),
        .i_a     (sq_res[GW]),
        .i_b     (mg_b),
        .i_side  (mg_in_side),
        .o_valid (mg_v),
        .o_p     (mg_p),
        .o_side  (mg_side)
    );

    // ---------------- gamma^2 / (gamma + 1): division cells
    logic               d2_v    [0:GW];
    logic [GW:0]        d2_rem  [0:GW];
    logic [GW-1:0]      d2_nq   [0:GW];
    logic [GW:0]        d2_d    [0:GW];
    logic [KGEW-1:0]    d2_side [0:GW];
    t_kge               d2_in_side;

    assign d2_in_side.k  = mg_side.k;
    assign d2_in_side.ge = mg_p[1][GEW-1:0];

    assign d2_v[0]    = mg_v;
    assign d2_rem[0]  = (GW+1)'(mg_p[0][2*GW-1:GW]);
    assign d2_nq[0]   = mg_p[0][GW-1:0];
    assign d2_d[0]    = (GW+1)'(mg_side.g) + ((GW+1)'(1) << GF);
    assign d2_side[0] = d2_in_side;

    for (genvar c = 0; c < GW; c++) begin : g_div2
        lbm_div_cell #(.DW(GW+1), .QB(GW), .SW(KGEW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d2_v[c]),
            .i_rem   (d2_rem[c]),
            .i_nq    (d2_nq[c]),
            .i_d     (d2_d[c]),
            .i_side  (d2_side[c]),
            .o_valid (d2_v[c+1]),
            .o_rem   (d2_rem[c+1]),
            .o_nq    (d2_nq[c+1]),
            .o_d     (d2_d[c+1]),
            .o_side  (d2_side[c+1])
        );
    end

    // ---------------- c * |beta.p|
    t_kge                       d2_out_side;
    t_kge                       mc_side;
    logic [0:0][DOTW-1:0]       mc_b;
    logic [0:0][CDW-1:0]        mc_p;
    logic                       mc_v;

    assign d2_out_side = t_kge'(d2_side[GW]);
    assign mc_b[0]     = d2_out_side.k.dmag;

    lbm_mul #(.WA(GW), .WB(DOTW), .LANES(1), .SW(KGEW)) u_mul_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d2_v[GW]),
        .i_a     (d2_nq[GW]),
        .i_b     (mc_b),
        .i_side  (d2_out_side),
        .o_valid (mc_v),
        .o_p     (mc_p),
        .o_side  (mc_side)
    );

    // ---------------- u = (c*dot + g*E << BF) >> BF, then magnitudes
    logic [UW-1:0]              ucd;
    logic [UW-1:0]              usum;
    logic                       r_uv, r_vv;
    logic [USW-1:0]             r_u;
    logic [2:0][BW-1:0]         r_ub;
    logic [2:0][PW-1:0]         r_up;
    logic                       r_uzero, r_uover;
    logic [USW-1:0]             r_umag;
    logic [2:0][BW-1:0]         r_bmag;
    t_sv                        r_vside;

    always_comb begin
        ucd  = mc_side.k.dneg ? ~UW'(mc_p[0]) : UW'(mc_p[0]);
        usum = ucd + (UW'(mc_side.ge) << BF) + UW'(mc_side.k.dneg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv <= 1'b0;
            r_vv <= 1'b0;
        end else if (en) begin
            r_uv <= mc_v;
            r_vv <= r_uv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u     <= usum[UW-1:BF];
            r_ub    <= mc_side.k.b;
            r_up    <= mc_side.k.p;
            r_uzero <= mc_side.k.zero;
            r_uover <= mc_side.k.over;
            r_umag  <= r_u[USW-1] ? USW'(-r_u) : r_u;
            for (int i = 0; i < 3; i++) begin
                r_bmag[i]      <= r_ub[i][BW-1] ? BW'(-r_ub[i]) : r_ub[i];
                r_vside.neg[i] <= r_u[USW-1] ^ r_ub[i][BW-1];
            end
            r_vside.p    <= r_up;
            r_vside.zero <= r_uzero;
            r_vside.over <= r_uover;
        end
    end

    // ---------------- u * beta_i per axis
    t_sv                        mu_side;
    logic [2:0][USW+BW-1:0]     mu_p;
    logic                       mu_v;

    lbm_mul #(.WA(USW), .WB(BW), .LANES(3), .SW(SVW)) u_mul_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vv),
        .i_a     (r_umag),
        .i_b     (r_bmag),
        .i_side  (r_vside),
        .o_valid (mu_v),
        .o_p     (mu_p),
        .o_side  (mu_side)
    );

    // ---------------- floor shift, add momentum, saturate
    logic signed [PRW-1:0]      sp [3];
    logic signed [PRW-1:0]      sh [3];
    logic                       r_wv, r_xv;
    logic [2:0][TW-1:0]         r_t;
    t_sv                        r_wside;
    logic signed [TW:0]         s [3];
    logic [2:0]                 sat;
    t_res                       n_x;
    t_res                       r_x;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sp[i] = mu_side.neg[i] ? -$signed({1'b0, mu_p[i]}) : $signed({1'b0, mu_p[i]});
            sh[i] = sp[i] >>> (GF + BF);
        end
    end

    always_comb begin
        n_x.st = ST_OK;
        for (int i = 0; i < 3; i++) begin
            s[i]   = $signed(r_t[i]) + $signed((TW+1)'($signed(r_wside.p[i])));
            sat[i] = !((&s[i][TW:PW-1]) || !(|s[i][TW:PW-1]));
            if (r_wside.over || r_wside.zero) begin
                n_x.o[i] = r_wside.p[i];
            end else if (sat[i]) begin
                n_x.o[i] = s[i][TW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
            end else begin
                n_x.o[i] = s[i][PW-1:0];
            end
        end
        if (r_wside.over) begin
            n_x.st = ST_FAST;
        end else if (!r_wside.zero && (|sat)) begin
            n_x.st = ST_SAT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_xv <= 1'b0;
        end else if (en) begin
            r_wv <= mu_v;
            r_xv <= r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= sh[i][TW-1:0];
            end
            r_wside <= mu_side;
            r_x     <= n_x;
        end
    end

    // ---------------- output register and skid
    logic r_ov;
    t_res r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_stall) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || !i_stall) begin
            r_ov <= r_xv;
        end else if (r_xv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (!r_ov || !i_stall) begin
            r_out <= r_x;
        end else begin
            r_skid <= r_x;
        end
    end

    assign o_stall  = r_sv;
    assign o_valid  = r_ov;
    assign o_out_x  = r_out.o[0];
    assign o_out_y  = r_out.o[1];
    assign o_out_z  = r_out.o[2];
    assign o_status = r_out.st;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid holds a transaction while output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !i_stall) |=> (r_ov && !r_sv))
        else $error("skid failed to drain into output register");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && i_stall) |=> r_sv)
        else $error("skid dropped a transaction under stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.st == ST_OK || r_out.st == ST_FAST || r_out.st == ST_SAT))
        else $error("undefined status code on output");

endmodule
